### hdl/msat_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and widths for the multi-slot alarm timer.
// No dependencies; imported by every module of the block.
package msat_pkg;

    // Field widths fixed by the item formats
    localparam int REQ_W      = 2;
    localparam int SLOT_W     = 4;
    localparam int SECS_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int MAX_SLOTS  = 16;

    // Stream bus widths
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 3;

    // Parameter defaults
    localparam int DEF_SLOTS      = 16;
    localparam int DEF_COUNT_BITS = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_IN_USE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // latch the incoming item, rewind the scan index
        logic do_op;    // execute a single-result operation and emit its result
        logic scan_en;  // process the slot at the scan index and advance
    } msat_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             started;
        logic             fire_any;
        logic             out_space;
        logic             scan_fire;
        logic             scan_last;
    } msat_stat_t;

endpackage

### hdl/msat_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the alarm timer: accept, execute, slot scan.
// Depends on msat_pkg; drives the datapath through msat_cmd_t.
module msat_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  msat_pkg::msat_stat_t stat,
    output msat_pkg::msat_cmd_t  cmd
);
    import msat_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.req_type != REQ_TICK)
                begin
                    if (stat.out_space)
                    begin
                        cmd.do_op  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.started && stat.fire_any)
                begin
                    state_next = S_SCAN;
                end
                else if (stat.out_space)
                begin
                    // idle tick result; counts still walk if ticking has begun
                    cmd.do_op  = 1'b1;
                    state_next = stat.started ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (!stat.scan_fire || stat.out_space)
                begin
                    cmd.scan_en = 1'b1;
                    if (stat.scan_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hdl/msat_dp.sv
`timescale 1ns / 1ps
// Datapath of the alarm timer: slot table, scan index and output register.
// Depends on msat_pkg; steered by msat_ctrl through msat_cmd_t.
module msat_dp #(
    parameter int SLOTS      = msat_pkg::DEF_SLOTS,
    parameter int COUNT_BITS = msat_pkg::DEF_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [msat_pkg::REQ_W-1:0]     in_req,
    input  logic [msat_pkg::SLOT_W-1:0]    in_slot,
    input  logic [msat_pkg::SECS_W-1:0]    in_seconds,
    input  msat_pkg::msat_cmd_t            cmd,
    output msat_pkg::msat_stat_t           stat,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [msat_pkg::STATUS_W-1:0]  out_status,
    output logic [msat_pkg::SLOT_W-1:0]    out_slot,
    output logic                           out_fired,
    output logic                           out_last
);
    import msat_pkg::*;

    // Only as many slots exist as the 4-bit index can name
    localparam int NSLOTS = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
    localparam int IDX_W  = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;

    // Latched item
    logic [REQ_W-1:0]      req_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [COUNT_BITS-1:0] secs_reg;

    // Slot table
    logic [NSLOTS-1:0]     in_use_reg;
    logic [COUNT_BITS-1:0] cnt_reg [NSLOTS];
    logic                  started_reg;
    logic [IDX_W-1:0]      sidx_reg;

    // Output register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic                  out_fired_reg;
    logic                  out_last_reg;

    logic                  free_any;
    logic [IDX_W-1:0]      free_idx;
    logic [NSLOTS-1:0]     fire_vec;
    logic                  later_fire;
    logic                  idx_ok;
    logic [IDX_W-1:0]      req_idx;
    logic                  set_ok;
    logic                  cur_live;
    logic                  cur_fire;
    logic                  out_space;
    logic                  out_load;
    logic [STATUS_W-1:0]   res_status;
    logic [SLOT_W-1:0]     res_slot;
    logic                  res_fired;
    logic                  res_last;

    // Lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NSLOTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Slots that fire on this tick, and whether one lies above the scan index
    always_comb
    begin
        later_fire = 1'b0;
        for (int j = 0; j < NSLOTS; j++)
        begin
            fire_vec[j] = in_use_reg[j] && (cnt_reg[j] == COUNT_BITS'(1));
            if (fire_vec[j] && (IDX_W'(j) > sidx_reg))
                later_fire = 1'b1;
        end
    end

    assign idx_ok    = ({1'b0, slot_reg} < (SLOT_W + 1)'(NSLOTS));
    assign req_idx   = slot_reg[IDX_W-1:0];
    assign set_ok    = idx_ok && in_use_reg[req_idx];
    assign cur_live  = in_use_reg[sidx_reg] && (cnt_reg[sidx_reg] != '0);
    assign cur_fire  = cur_live && (cnt_reg[sidx_reg] == COUNT_BITS'(1));
    assign out_space = !out_valid_reg || out_ready;

    // Result selection
    always_comb
    begin
        out_load   = 1'b0;
        res_status = STAT_OK;
        res_slot   = '0;
        res_fired  = 1'b0;
        res_last   = 1'b1;
        if (cmd.do_op)
        begin
            out_load = 1'b1;
            unique case (req_reg)
                REQ_ALLOC:
                begin
                    if (free_any)
                        res_slot = SLOT_W'(free_idx);
                    else
                        res_status = STAT_FULL;
                end
                REQ_SET:
                begin
                    if (!set_ok)
                        res_status = STAT_NOT_IN_USE;
                end
                REQ_RELEASE: ;
                REQ_TICK: ;
            endcase
        end
        else if (cmd.scan_en && cur_fire)
        begin
            out_load  = 1'b1;
            res_slot  = SLOT_W'(sidx_reg);
            res_fired = 1'b1;
            res_last  = !later_fire;
        end
    end

    // Item latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg  <= in_req;
            slot_reg <= in_slot;
            secs_reg <= COUNT_BITS'(in_seconds);
        end
    end

    // In-use bits, start flag and scan index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg  <= '0;
            started_reg <= 1'b0;
            sidx_reg    <= '0;
        end
        else
        begin
            if (cmd.accept)
                sidx_reg <= '0;
            else if (cmd.scan_en)
                sidx_reg <= sidx_reg + 1'b1;
            if (cmd.do_op)
            begin
                if ((req_reg == REQ_ALLOC) && free_any)
                begin
                    in_use_reg[free_idx] <= 1'b1;
                    started_reg          <= 1'b1;
                end
                else if ((req_reg == REQ_RELEASE) && idx_ok)
                begin
                    in_use_reg[req_idx] <= 1'b0;
                end
            end
        end
    end

    // Countdown values
    always_ff @(posedge clk)
    begin
        if (cmd.do_op)
        begin
            unique case (req_reg)
                REQ_ALLOC:
                begin
                    if (free_any)
                        cnt_reg[free_idx] <= '0;
                end
                REQ_SET:
                begin
                    if (set_ok)
                        cnt_reg[req_idx] <= secs_reg;
                end
                REQ_RELEASE:
                begin
                    if (idx_ok)
                        cnt_reg[req_idx] <= '0;
                end
                REQ_TICK: ;
            endcase
        end
        else if (cmd.scan_en && cur_live)
        begin
            cnt_reg[sidx_reg] <= cnt_reg[sidx_reg] - 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
            out_fired_reg  <= res_fired;
            out_last_reg   <= res_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_fired  = out_fired_reg;
    assign out_last   = out_last_reg;

    // Status to controller
    assign stat.req_type  = req_reg;
    assign stat.started   = started_reg;
    assign stat.fire_any  = |fire_vec;
    assign stat.out_space = out_space;
    assign stat.scan_fire = cur_fire;
    assign stat.scan_last = (sidx_reg == IDX_W'(NSLOTS - 1));

endmodule

### hdl/multi_slot_alarm_timer_top.sv
`timescale 1ns / 1ps
// Sequencing: allocate, set, release and a tick before the first allocation register their one
// result from the execute state that follows the take, then return to idle.
// A tick after the first allocation passes a check state, then a one-slot-per-cycle scan of all
// min(SLOTS,16) slots that registers slot k's fired result, stalling while the output is full.
// A result waits in its state while the output register is full; one item in work at a time.
// Reset (async, active low) frees all slots, clears the start flag, idles the FSM, drops valid.
module multi_slot_alarm_timer_top #(
    parameter int SLOTS      = msat_pkg::DEF_SLOTS,
    parameter int COUNT_BITS = msat_pkg::DEF_COUNT_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [msat_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // slot[3:0], seconds[19:4]
    input  logic [msat_pkg::IN_USER_W-1:0]    s_axis_tuser,  // req_type[1:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [msat_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // slot_out[3:0]
    output logic [msat_pkg::OUT_USER_W-1:0]   m_axis_tuser,  // status[1:0], fired[2]
    output logic                              m_axis_tlast   // last
);
    import msat_pkg::*;

    msat_cmd_t           cmd;
    msat_stat_t          stat;
    logic [STATUS_W-1:0] out_status;
    logic [SLOT_W-1:0]   out_slot;
    logic                out_fired;

    // Controller
    msat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    msat_dp #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_req     (s_axis_tuser),
        .in_slot    (s_axis_tdata[SLOT_W-1:0]),
        .in_seconds (s_axis_tdata[SLOT_W+SECS_W-1:SLOT_W]),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (out_status),
        .out_slot   (out_slot),
        .out_fired  (out_fired),
        .out_last   (m_axis_tlast)
    );

    // Output packing
    assign m_axis_tdata = {{(OUT_DATA_W - SLOT_W){1'b0}}, out_slot};
    assign m_axis_tuser = {out_fired, out_status};

endmodule

### hdl/msat_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the alarm timer, bound to the top level.
// Depends on msat_pkg for status codes.
module msat_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [msat_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
    import msat_pkg::*;

    // Result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before it was taken");

    // One item in work: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // No result while reset is held
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // Fired events always carry ok status
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == STAT_OK)
        else $error("fired event with error status");

endmodule

bind multi_slot_alarm_timer_top msat_chk u_msat_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser)
);
